>>> design/group_membership_table_top_macros.svh
// Assertion macros shared by the checker of the membership table.
`ifndef GROUP_MEMBERSHIP_TABLE_TOP_MACROS_SVH
`define GROUP_MEMBERSHIP_TABLE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GMT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("membership table check failed");

// Consequent must hold in the cycle after the antecedent.
`define GMT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("membership table check failed");

`endif

>>> design/gmt_pkg.sv
package gmt_pkg;

   // Default size of the flat table; two slots are header bytes and are not kept.
   localparam int TABLE_SLOTS_DEF = 32;
   localparam int CNT_W_DEF       = $clog2(TABLE_SLOTS_DEF - 1);

   // A merge only acts when the remote header carries this tag.
   localparam logic [7:0] MERGE_TAG_OK = 8'hFF;

   typedef enum logic [2:0] {
      OP_INIT   = 3'd0,
      OP_ADD    = 3'd1,
      OP_FIND   = 3'd2,
      OP_DELETE = 3'd3,
      OP_MERGE  = 3'd4,
      OP_READ   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_LOOKUP = 2'd1,
      S_APPLY  = 2'd2
   } state_type;

   // Commands broadcast from the controller to every cell of the row.
   typedef struct packed {
      logic look;
      logic clear;
      logic append;
      logic shift;
   } cell_cmd_type;

endpackage

>>> design/gmt_cell.sv
module gmt_cell #(
   parameter int CNT_W = gmt_pkg::CNT_W_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gmt_pkg::cell_cmd_type cmd,
   input  logic [7:0]            key,
   input  logic [CNT_W-1:0]      count,
   input  logic [CNT_W-1:0]      index,
   input  logic [7:0]            right_value,
   input  logic                  hit_in,
   output logic [7:0]            value,
   output logic                  hit_out,
   output logic                  first
);
   import gmt_pkg::*;

   logic [7:0] value_ff;
   logic [7:0] value_in;
   logic       match_ff;
   logic       match_in;

   // A slot matches only when it lies inside the occupied part of the list.
   always_comb begin
      match_in = match_ff;
      if (cmd.look) begin
         match_in = (value_ff == key) && (index < count);
      end
   end

   // The match seen so far travels to the right; the first one owns the hit.
   assign hit_out = hit_in | match_ff;
   assign first   = match_ff & ~hit_in;
   assign value   = value_ff;

   // Init clears the row and seeds slot zero; delete pulls the right neighbour in.
   always_comb begin
      value_in = value_ff;
      if (cmd.clear) begin
         value_in = (index == '0) ? key : 8'd0;
      end else if (cmd.append && (index == count)) begin
         value_in = key;
      end else if (cmd.shift && hit_out) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= 8'd0;
      end else begin
         value_ff <= value_in;
      end
      match_ff <= match_in;
   end

endmodule

>>> design/group_membership_table_top.sv
// Channel    Direction  Handshake            Payload
// req_       in         req_valid/req_stall  op, node_id, merge_tag, read_position
// rsp_       out        rsp_valid/rsp_stall  success, found, found_position,
//                                            entry_value, member_count
// A request passes through a lookup state, in which every cell compares its entry with
// the node ID, and an apply state, in which the first match is resolved along the row
// and the list is updated. The next request may be taken as the last one is applied.
// A finished result waits in the output register, and the next request may be
// taken meanwhile; a held result delays only the update cycle of the next one.
// Reset leaves an empty list with all entries zero.
module group_membership_table_top #(
   parameter int TABLE_SLOTS = gmt_pkg::TABLE_SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [7:0] req_node_id,
   input  logic [7:0] req_merge_tag,
   input  logic [4:0] req_read_position,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_success,
   output logic       rsp_found,
   output logic [4:0] rsp_found_position,
   output logic [7:0] rsp_entry_value,
   output logic [4:0] rsp_member_count
);
   import gmt_pkg::*;

   localparam int CAP   = TABLE_SLOTS - 2;
   localparam int CNT_W = $clog2(CAP + 1);
   localparam int PW    = (CNT_W > 5) ? CNT_W : 5;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   logic [7:0]       id_ff, id_in;
   logic [7:0]       tag_ff, tag_in;
   logic [4:0]       pos_ff, pos_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_success_ff, rsp_success_in;
   logic             rsp_found_ff, rsp_found_in;
   logic [4:0]       rsp_fpos_ff, rsp_fpos_in;
   logic [7:0]       rsp_entry_ff, rsp_entry_in;
   logic [4:0]       rsp_count_ff, rsp_count_in;

   cell_cmd_type     cmd;
   logic [7:0]       cell_value [CAP];
   logic [7:0]       cell_right [CAP];
   logic             cell_hit_in [CAP];
   logic             cell_hit_out [CAP];
   logic             cell_first [CAP];

   logic             accept;
   logic             fire;
   logic             is_lookup;
   logic             found;
   logic             full;
   logic             do_append;
   logic             do_shift;
   logic [PW-1:0]    fpos_acc;
   logic [7:0]       read_acc;
   logic [PW-1:0]    cnt_wide;

   // Row of cells: hit flags run left to right, entries shift right to left.
   for (genvar i = 0; i < CAP; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_hit_in[i] = 1'b0;
      end else begin : g_link
         assign cell_hit_in[i] = cell_hit_out[i-1];
      end
      if (i == CAP - 1) begin : g_tail
         assign cell_right[i] = 8'd0;
      end else begin : g_next
         assign cell_right[i] = cell_value[i+1];
      end

      gmt_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .key         (id_ff),
         .count       (cnt_ff),
         .index       (CNT_W'(i)),
         .right_value (cell_right[i]),
         .hit_in      (cell_hit_in[i]),
         .value       (cell_value[i]),
         .hit_out     (cell_hit_out[i]),
         .first       (cell_first[i])
      );
   end

   // Position of the first match and the entry at the read position.
   always_comb begin
      fpos_acc = '0;
      read_acc = 8'd0;
      for (int i = 0; i < CAP; i++) begin
         if (cell_first[i]) begin
            fpos_acc = fpos_acc | PW'(i);
         end
         if (PW'(i) == PW'(pos_ff)) begin
            read_acc = read_acc | cell_value[i];
         end
      end
   end

   assign fire      = (state_ff == S_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((state_ff == S_IDLE) || fire);
   assign accept    = req_valid && !req_stall;
   assign is_lookup = (op_ff == OP_ADD) || (op_ff == OP_FIND) ||
                      (op_ff == OP_DELETE) || (op_ff == OP_MERGE);
   assign found     = is_lookup && cell_hit_out[CAP-1];
   assign full      = (cnt_ff >= CNT_W'(CAP));

   // Operation decode for the update cycle and the result fields.
   always_comb begin
      do_append      = 1'b0;
      do_shift       = 1'b0;
      cnt_in         = cnt_ff;
      rsp_success_in = 1'b0;
      rsp_entry_in   = 8'd0;
      case (op_ff)
         OP_INIT: begin
            cnt_in         = CNT_W'(1);
            rsp_success_in = 1'b1;
         end
         OP_ADD: begin
            do_append      = !full;
            rsp_success_in = !full;
         end
         OP_FIND: begin
            rsp_success_in = found;
         end
         OP_DELETE: begin
            do_shift       = found;
            rsp_success_in = found;
         end
         OP_MERGE: begin
            if (tag_ff == MERGE_TAG_OK) begin
               do_append      = !found && !full;
               rsp_success_in = found || !full;
            end
         end
         OP_READ: begin
            if (PW'(pos_ff) < PW'(cnt_ff)) begin
               rsp_entry_in   = read_acc;
               rsp_success_in = 1'b1;
            end
         end
         default: begin
            rsp_success_in = 1'b0;
         end
      endcase
      if (do_append) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_shift) begin
         cnt_in = cnt_ff - 1'b1;
      end
      if (!fire) begin
         cnt_in = cnt_ff;
      end
   end

   // Commands for the row of cells.
   always_comb begin
      cmd.look   = (state_ff == S_LOOKUP);
      cmd.clear  = fire && (op_ff == OP_INIT);
      cmd.append = fire && do_append;
      cmd.shift  = fire && do_shift;
   end

   assign cnt_wide = PW'(cnt_in);

   // Result register: loaded on the update cycle, held while stalled.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = found;
      rsp_fpos_in  = found ? fpos_acc[4:0] : 5'd0;
      rsp_count_in = cnt_wide[4:0];
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Controller and request capture.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      id_in    = id_ff;
      tag_in   = tag_ff;
      pos_in   = pos_ff;
      if (accept) begin
         op_in  = op_type'(req_op);
         id_in  = req_node_id;
         tag_in = req_merge_tag;
         pos_in = req_read_position;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (fire) begin
               state_in = accept ? S_LOOKUP : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff  <= op_in;
      id_ff  <= id_in;
      tag_ff <= tag_in;
      pos_ff <= pos_in;
      if (fire) begin
         rsp_success_ff <= rsp_success_in;
         rsp_found_ff   <= rsp_found_in;
         rsp_fpos_ff    <= rsp_fpos_in;
         rsp_entry_ff   <= rsp_entry_in;
         rsp_count_ff   <= rsp_count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_success        = rsp_success_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_entry_value    = rsp_entry_ff;
   assign rsp_member_count   = rsp_count_ff;

endmodule

>>> design/gmt_checker.sv
`include "group_membership_table_top_macros.svh"

module gmt_checker #(
   parameter int TABLE_SLOTS = gmt_pkg::TABLE_SLOTS_DEF
) (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_success,
   input logic       rsp_found,
   input logic [4:0] rsp_found_position,
   input logic [7:0] rsp_entry_value,
   input logic [4:0] rsp_member_count
);
   import gmt_pkg::*;

   // Largest count the list can report; a wide table is bounded by the port alone.
   localparam logic [4:0] COUNT_MAX = (TABLE_SLOTS > 33) ? 5'd31 : 5'(TABLE_SLOTS - 2);

   logic [19:0] rsp_fields;

   // All result fields side by side, so that one stability check covers them.
   assign rsp_fields = {rsp_success, rsp_found, rsp_found_position, rsp_entry_value,
                        rsp_member_count};

   // A held result keeps its valid and its fields.
   `GMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_fields))

   // The compare cycle follows every request, so no request is taken right after one.
   `GMT_ASSERT_NEXT(a_req_spacing, req_valid && !req_stall, req_stall)

   // The count never exceeds the capacity of the list.
   `GMT_ASSERT_NOW(a_count_cap, rsp_valid, rsp_member_count <= COUNT_MAX)

   // Only a successful read returns an entry.
   `GMT_ASSERT_NOW(a_entry_success, rsp_valid && !rsp_success, rsp_entry_value == 8'd0)

   // A position is reported only with a match.
   `GMT_ASSERT_NOW(a_pos_found, rsp_valid && !rsp_found, rsp_found_position == 5'd0)

endmodule

bind group_membership_table_top gmt_checker #(
   .TABLE_SLOTS (TABLE_SLOTS)
) u_gmt_checker (.*);

>>> tb/group_membership_table_top_tb.sv
module group_membership_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gmt_pkg::*;

   // Op codes that the block leaves undefined; they must change nothing.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam int RANDOM_REQUESTS = 1050;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 20;

   // One result of the table, field by field.
   typedef struct packed {
      logic       success;
      logic       found;
      logic [4:0] found_position;
      logic [7:0] entry_value;
      logic [4:0] member_count;
   } membership_result_type;

   // How a stretch of random requests tends to move the member count.
   typedef enum {CHURN_GROW, CHURN_SHRINK, CHURN_MIXED} churn_type;

   // Mirror of the membership list and the queue of results it predicts.
   class membership_scoreboard;
      localparam int CAPACITY = TABLE_SLOTS_DEF - 2;

      logic [7:0]            slot_ids [CAPACITY];
      int                    held;
      membership_result_type outstanding [$];
      int                    failures;
      int                    requests_noted;
      int                    results_checked;
      int                    full_rejects;
      int                    removals;

      function new();
         foreach (slot_ids[k]) slot_ids[k] = 8'h00;
         held            = 0;
         failures        = 0;
         requests_noted  = 0;
         results_checked = 0;
         full_rejects    = 0;
         removals        = 0;
      endfunction

      function int pending();
         return outstanding.size();
      endfunction

      // Appends at the tail unless the list is already full.
      function logic append_id(logic [7:0] id);
         if (held >= CAPACITY) begin
            full_rejects++;
            return 1'b0;
         end
         slot_ids[held] = id;
         held++;
         return 1'b1;
      endfunction

      // Applies one accepted request to the mirror and queues its result.
      function void note_request(logic [2:0] op, logic [7:0] id, logic [7:0] tag,
                                 logic [4:0] pos);
         membership_result_type res;
         int                    hit;
         int                    k;
         res = '0;
         hit = -1;
         requests_noted++;

         // The lookup ops report the first match as it stood before the update.
         if (op == OP_ADD || op == OP_FIND || op == OP_DELETE || op == OP_MERGE) begin
            for (k = 0; k < held; k++) begin
               if (hit < 0 && slot_ids[k] == id) hit = k;
            end
         end
         if (hit >= 0) begin
            res.found          = 1'b1;
            res.found_position = 5'(hit);
         end

         case (op)
            OP_INIT: begin
               foreach (slot_ids[j]) slot_ids[j] = 8'h00;
               held        = 0;
               res.success = append_id(id);
            end
            OP_ADD: begin
               res.success = append_id(id);
            end
            OP_FIND: begin
               res.success = res.found;
            end
            OP_DELETE: begin
               // Later entries close the gap and the vacated tail slot is zeroed.
               if (hit >= 0) begin
                  for (k = hit; k + 1 < held; k++) slot_ids[k] = slot_ids[k + 1];
                  held--;
                  slot_ids[held] = 8'h00;
                  res.success    = 1'b1;
                  removals++;
               end
            end
            OP_MERGE: begin
               if (tag == MERGE_TAG_OK) begin
                  res.success = (hit >= 0) ? 1'b1 : append_id(id);
               end
            end
            OP_READ: begin
               if (pos < held) begin
                  res.entry_value = slot_ids[pos];
                  res.success     = 1'b1;
               end
            end
            default: begin
            end
         endcase

         res.member_count = 5'(held);
         outstanding.push_back(res);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
         failures++;
      endtask

      // Compares one accepted result with the oldest prediction.
      task check_response(membership_result_type got);
         membership_result_type want;
         if (outstanding.size() == 0) begin
            report_mismatch("result count beyond requests", results_checked + 1,
                            requests_noted);
            return;
         end
         want = outstanding.pop_front();
         results_checked++;
         if (got.success !== want.success)
            report_mismatch("success", got.success, want.success);
         if (got.found !== want.found)
            report_mismatch("found", got.found, want.found);
         if (got.found_position !== want.found_position)
            report_mismatch("found_position", got.found_position, want.found_position);
         if (got.entry_value !== want.entry_value)
            report_mismatch("entry_value", got.entry_value, want.entry_value);
         if (got.member_count !== want.member_count)
            report_mismatch("member_count", got.member_count, want.member_count);
      endtask
   endclass

   logic       clock;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [2:0] req_op            = 3'd0;
   logic [7:0] req_node_id       = 8'h00;
   logic [7:0] req_merge_tag     = 8'h00;
   logic [4:0] req_read_position = 5'd0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic       rsp_success;
   logic       rsp_found;
   logic [4:0] rsp_found_position;
   logic [7:0] rsp_entry_value;
   logic [4:0] rsp_member_count;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_armed    = 1'b0;

   membership_scoreboard membership = new();

   group_membership_table_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_node_id        (req_node_id),
      .req_merge_tag      (req_merge_tag),
      .req_read_position  (req_read_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_success        (rsp_success),
      .rsp_found          (rsp_found),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_value    (rsp_entry_value),
      .rsp_member_count   (rsp_member_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offers one request, with random idle cycles first, and returns at the
   // edge where the block takes it.
   task automatic send_request(input logic [2:0] op, input logic [7:0] id,
                               input logic [7:0] tag, input logic [4:0] pos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_node_id       <= id;
      req_merge_tag     <= tag;
      req_read_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      membership.note_request(op, id, tag, pos);
   endtask

   // Result side: checks each accepted result and decides the stall for the next
   // cycle, including one long hold-off when asked for.
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            membership.check_response('{rsp_success, rsp_found, rsp_found_position,
                                        rsp_entry_value, rsp_member_count});
         end
         if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Watchdog: too long without any transfer on either side ends the run.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles", $realtime, quiet_cycles);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      churn_type  churn;
      int         churn_left;
      int         counted;
      int         roll;
      int         add_w;
      int         merge_w;
      int         find_w;
      int         delete_w;
      int         read_w;
      int         pick;
      logic [2:0] op;
      logic [7:0] id;
      logic [7:0] tag;
      logic [4:0] pos;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: empty list, duplicates, merges with both tags,
      // delete from the front and the tail, reads past the count, spare codes.
      send_request(OP_READ,   8'h00, 8'h00, 5'd0);
      send_request(OP_FIND,   8'h00, 8'h00, 5'd0);
      send_request(OP_DELETE, 8'h00, 8'h00, 5'd0);
      send_request(OP_MERGE,  8'hFF, 8'h00, 5'd0);
      send_request(OP_ADD,    8'hFF, 8'h00, 5'd0);
      send_request(OP_INIT,   8'hA5, 8'h00, 5'd0);
      send_request(OP_ADD,    8'h00, 8'h00, 5'd0);
      send_request(OP_ADD,    8'hFF, 8'hFF, 5'd31);
      send_request(OP_ADD,    8'hA5, 8'h00, 5'd0);
      send_request(OP_FIND,   8'hA5, 8'h00, 5'd0);
      send_request(OP_FIND,   8'hFF, 8'h00, 5'd0);
      send_request(OP_FIND,   8'h5A, 8'h00, 5'd0);
      send_request(OP_READ,   8'h00, 8'h00, 5'd3);
      send_request(OP_READ,   8'h00, 8'h00, 5'd29);
      send_request(OP_MERGE,  8'h5A, MERGE_TAG_OK, 5'd0);
      send_request(OP_MERGE,  8'h00, MERGE_TAG_OK, 5'd0);
      send_request(OP_MERGE,  8'h33, 8'h7F, 5'd0);
      send_request(OP_MERGE,  8'hA5, 8'hFE, 5'd0);
      send_request(OP_DELETE, 8'hA5, 8'h00, 5'd0);
      send_request(OP_READ,   8'h00, 8'h00, 5'd2);
      send_request(OP_SPARE_6, 8'hFF, 8'hFF, 5'd29);
      send_request(OP_SPARE_7, 8'h00, 8'h00, 5'd0);
      send_request(OP_DELETE, 8'h5A, 8'h00, 5'd0);
      send_request(OP_READ,   8'h00, 8'h00, 5'd4);

      // Random requests in stretches that grow, shrink or churn the list, so
      // that both the full and the empty list are reached again and again.
      churn_left = 0;
      counted    = 0;
      churn      = CHURN_MIXED;
      while (counted < RANDOM_REQUESTS) begin
         if (counted == 0) begin
            send_idle_pct = 18;
            recv_idle_pct = 50;
         end else if (counted == RANDOM_REQUESTS / 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 18;
         end else if (counted == 2 * RANDOM_REQUESTS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            hold_armed    = 1'b1;
         end

         if (churn_left == 0) begin
            pick       = $urandom_range(2);
            churn      = (pick == 0) ? CHURN_GROW : (pick == 1) ? CHURN_SHRINK : CHURN_MIXED;
            churn_left = $urandom_range(30, 70);
         end
         churn_left--;

         case (churn)
            CHURN_GROW:   begin add_w = 50; merge_w = 20; find_w = 10; delete_w = 8;  read_w = 9;  end
            CHURN_SHRINK: begin add_w = 8;  merge_w = 7;  find_w = 15; delete_w = 45; read_w = 22; end
            default:      begin add_w = 25; merge_w = 15; find_w = 20; delete_w = 20; read_w = 17; end
         endcase

         roll = $urandom_range(99);
         if (roll < add_w)                                      op = OP_ADD;
         else if (roll < add_w + merge_w)                       op = OP_MERGE;
         else if (roll < add_w + merge_w + find_w)              op = OP_FIND;
         else if (roll < add_w + merge_w + find_w + delete_w)   op = OP_DELETE;
         else if (roll < 97)                                    op = OP_READ;
         else if (roll == 97)                                   op = OP_INIT;
         else if (roll == 98)                                   op = OP_SPARE_6;
         else                                                   op = OP_SPARE_7;

         // Mostly a small pool of IDs so that lookups hit and duplicates pile up.
         pick = $urandom_range(11);
         if ($urandom_range(3) != 0) id = (pick == 11) ? 8'hFF : 8'(pick);
         else                        id = 8'($urandom_range(255));
         tag = ($urandom_range(9) < 8) ? MERGE_TAG_OK : 8'($urandom_range(255));
         pos = 5'($urandom_range(29));

         send_request(op, id, tag, pos);
         counted++;
      end
      req_valid <= 1'b0;

      // Drain: every prediction must be met, then watch for stray results.
      while (membership.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results from %0d requests over all op codes, idling on either side.",
               membership.results_checked, membership.requests_noted);
      $display("Refusals at a full list: %0d; deletions: %0d; one result hold-off of %0d cycles.",
               membership.full_rejects, membership.removals, HOLD_OFF_CYCLES);
      if (membership.failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
